// ----- rtl/core/mcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_pkg: shared types, constants and code table
// holds the symbol table lookup and the item and result structs
// ----------------------------------------------------------------------------
package mcd_pkg;

  // symbol geometry
  localparam int MAX_CODE_LEN_DEF = 7;
  localparam int TableCodeW       = 7;
  localparam int TableLenW        = 3;

  // character codes
  localparam logic [7:0] DotChar      = 8'h2e;
  localparam logic [7:0] DashChar     = 8'h2d;
  localparam logic [7:0] SepResetChar = 8'h20;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-3:0] CfgSepIdx = '0;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] letter;
  } lookup_t;

  // key is {length, elements}, oldest element in the highest used bit, dash = 1
  function automatic lookup_t code_lookup(input logic [TableLenW-1:0]  len,
                                          input logic [TableCodeW-1:0] bits);
    lookup_t r;
    r.hit    = 1'b1;
    r.letter = 8'h00;
    case ({len, bits})
      10'b010_0000001: r.letter = "a";
      10'b100_0001000: r.letter = "b";
      10'b100_0001010: r.letter = "c";
      10'b011_0000100: r.letter = "d";
      10'b001_0000000: r.letter = "e";
      10'b100_0000010: r.letter = "f";
      10'b011_0000110: r.letter = "g";
      10'b100_0000000: r.letter = "h";
      10'b010_0000000: r.letter = "i";
      10'b100_0000111: r.letter = "j";
      10'b011_0000101: r.letter = "k";
      10'b100_0000100: r.letter = "l";
      10'b010_0000011: r.letter = "m";
      10'b010_0000010: r.letter = "n";
      10'b011_0000111: r.letter = "o";
      10'b100_0000110: r.letter = "p";
      10'b100_0001101: r.letter = "q";
      10'b011_0000010: r.letter = "r";
      10'b011_0000000: r.letter = "s";
      10'b001_0000001: r.letter = "t";
      10'b011_0000001: r.letter = "u";
      10'b100_0000001: r.letter = "v";
      10'b011_0000011: r.letter = "w";
      10'b100_0001001: r.letter = "x";
      10'b100_0001011: r.letter = "y";
      10'b100_0001100: r.letter = "z";
      10'b101_0011111: r.letter = "0";
      10'b101_0001111: r.letter = "1";
      10'b101_0000111: r.letter = "2";
      10'b101_0000011: r.letter = "3";
      10'b101_0000001: r.letter = "4";
      10'b101_0000000: r.letter = "5";
      10'b101_0010000: r.letter = "6";
      10'b101_0011000: r.letter = "7";
      10'b101_0011100: r.letter = "8";
      10'b101_0011110: r.letter = "9";
      10'b110_0010101: r.letter = 8'h2e; // period
      10'b110_0111000: r.letter = 8'h3a; // colon
      10'b110_0110011: r.letter = 8'h2c; // comma
      10'b110_0101010: r.letter = 8'h3b; // semicolon
      10'b110_0001100: r.letter = 8'h3f; // question mark
      10'b101_0010001: r.letter = 8'h3d; // equals
      10'b110_0011110: r.letter = 8'h27; // apostrophe
      10'b101_0010010: r.letter = 8'h2f; // slash
      10'b110_0101011: r.letter = 8'h21; // exclamation
      10'b110_0100001: r.letter = 8'h20; // word break
      10'b110_0001101: r.letter = 8'h5f; // underscore
      10'b110_0010010: r.letter = 8'h22; // double quote
      10'b101_0010110: r.letter = 8'h28; // open paren
      10'b110_0101101: r.letter = 8'h29; // close paren
      10'b111_0001001: r.letter = 8'h24; // dollar
      10'b101_0001000: r.letter = 8'h26; // ampersand
      10'b110_0011010: r.letter = 8'h40; // at sign
      10'b101_0001010: r.letter = 8'h2b; // plus
      default:         r.hit    = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/mcd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_cfg: configuration registers
// apb-style write/read port holding the separator character
// ----------------------------------------------------------------------------
module mcd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mcd_pkg::CfgDataW-1:0]  pwdata,
  output logic [mcd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output logic [7:0]                    sep_char_o
);
  import mcd_pkg::*;

  logic       sep_sel;
  logic       sep_we;
  logic [7:0] sep_q, sep_d;

  // word index is the address without its byte offset
  assign sep_sel = (paddr[CfgAddrW-1:2] == CfgSepIdx);
  assign sep_we  = psel && penable && pwrite && sep_sel;
  assign sep_d   = sep_we ? pwdata[7:0] : sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepResetChar;
    end else begin
      sep_q <= sep_d;
    end
  end

  assign prdata     = sep_sel ? {{(CfgDataW-8){1'b0}}, sep_q} : '0;
  assign pready     = 1'b1;
  assign sep_char_o = sep_q;

endmodule

// ----- rtl/core/mcd_symbol.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_symbol: symbol accumulator and table match
// gathers dots and dashes, decodes on separator or last character
// ----------------------------------------------------------------------------
module mcd_symbol #(
  parameter int MAX_CODE_LENGTH = mcd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  mcd_pkg::item_t   item_i,
  input  logic [7:0]       sep_char_i,
  output mcd_pkg::lookup_t res_o
);
  import mcd_pkg::*;

  localparam int LenW = $clog2(MAX_CODE_LENGTH + 1);

  logic [MAX_CODE_LENGTH-1:0] bits_q, bits_d, bits_n;
  logic [LenW-1:0]            len_q, len_d, len_n;
  logic                       bad_q, bad_d, bad_n;
  logic                       is_sep, is_elem, is_dash, sym_end, full;
  lookup_t                    tab;

  assign is_sep  = (item_i.ch == sep_char_i);
  assign is_dash = (item_i.ch == DashChar);
  assign is_elem = (item_i.ch == DotChar) || is_dash;
  assign full    = (len_q >= LenW'(MAX_CODE_LENGTH));
  assign sym_end = is_sep || item_i.last;

  // symbol after taking this character in
  always_comb begin
    bits_n = bits_q;
    len_n  = len_q;
    bad_n  = bad_q;
    if (!is_sep) begin
      if (is_elem && !full) begin
        bits_n = {bits_q[MAX_CODE_LENGTH-2:0], is_dash};
        len_n  = len_q + LenW'(1);
      end else begin
        bad_n = 1'b1;
      end
    end
  end

  assign tab = code_lookup(TableLenW'(len_n), TableCodeW'(bits_n));

  always_comb begin
    res_o.hit    = sym_end && !bad_n && (len_n != '0) && tab.hit;
    res_o.letter = tab.letter;
  end

  // clear after every symbol end
  assign bits_d = !step_en_i ? bits_q : (sym_end ? '0 : bits_n);
  assign len_d  = !step_en_i ? len_q  : (sym_end ? '0 : len_n);
  assign bad_d  = !step_en_i ? bad_q  : (sym_end ? 1'b0 : bad_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      len_q  <= '0;
      bad_q  <= 1'b0;
    end else begin
      bits_q <= bits_d;
      len_q  <= len_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ----- rtl/core/morse_code_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_decoder: international morse code decoder
// turns a stream of dot, dash and separator characters into ascii letters
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | request   | in_valid_i / in_stall_o | symbol_char_i, is_last_i
//  out     | result    | out_valid_o/out_stall_i | decoded_char_o
//  cfg     | apb rd/wr | psel, penable, pwrite   | paddr, pwdata, prdata
//
//  one character is taken every cycle while in_stall_o is low; a decoded letter
//  passes the input register, then the result register, before out_valid_o rises
//  the symbol match is one shallow table decode between those two registers
//  reset clears the accumulator, both valid flags and sets the separator to space
//  a stalled result only holds the pipe when the next request would produce one
// ----------------------------------------------------------------------------
module morse_code_decoder #(
  parameter int MAX_CODE_LENGTH = mcd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // character requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    symbol_char_i,
  input  logic                          is_last_i,
  // decoded letters
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    decoded_char_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mcd_pkg::CfgDataW-1:0]  pwdata,
  output logic [mcd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import mcd_pkg::*;

  logic [7:0] sep_char_w;

  // input register
  logic       in_valid_q, in_valid_d;
  item_t      in_item_q, in_item_d;
  logic       in_take;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_free;

  lookup_t    res;
  logic       adv;

  mcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sep_char_o (sep_char_w)
  );

  // the registered request is processed by the accumulator and table match
  mcd_symbol #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_symbol (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (adv),
    .item_i     (in_item_q),
    .sep_char_i (sep_char_w),
    .res_o      (res)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // a request with no result never waits on the output side
  assign adv        = in_valid_q && (!res.hit || out_free);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (in_take) begin
      in_valid_d     = 1'b1;
      in_item_d.ch   = symbol_char_i;
      in_item_d.last = is_last_i;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (adv && res.hit) begin
      out_valid_d = 1'b1;
      out_char_d  = res.letter;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_item_q  <= in_item_d;
    out_char_q <= out_char_d;
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_char_o = out_char_q;

`ifndef NO_ASSERTIONS
  // the input side only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result slot was free");

  // a new result always comes from a registered request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(in_valid_q))
    else $error("result appeared without a request");

  // a held request keeps its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (in_valid_q && $stable(in_item_q)))
    else $error("held request lost or changed");

  // a separator that matches nothing raises no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (sep_char_w == in_item_q.ch) && !res.hit) |=> !out_valid_o || $past(out_valid_o))
    else $error("separator without match produced a result");
`endif

endmodule

// ----- tb/morse_code_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_decoder_tb: self-checking bench for the morse code decoder
// drives dot, dash, separator and noise characters with random gaps and
// random output stalls, predicts each decoded letter and compares in order
// ----------------------------------------------------------------------------
module morse_code_decoder_tb;
  import mcd_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int MAX_CODE_LEN = MAX_CODE_LEN_DEF;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS  = 305;
  localparam int NUM_PHASES   = 6;

  // register map: separator at word 0, anything else is not decoded
  localparam logic [CfgAddrW-1:0] SEP_ADDR   = {CfgSepIdx, 2'b00};
  localparam logic [CfgAddrW-1:0] SPARE_ADDR = 3'h4;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,  // expectation from the predictor
    ROW_NONE,     // no letter may come out
    ROW_CHAR,     // letter typed in the row
    ROW_SEP       // not a request: reprogram the separator to ch
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] ch;
    logic       last;
    logic [7:0] letter;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 29;
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // dot dash closed by the reset separator
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_CHAR,    " ",      1'b0, "a"},
    // separator on an empty symbol
    '{ROW_NONE,    " ",      1'b0, 8'h00},
    // word break code, its last element flagged as end of message
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_CHAR,    DashChar, 1'b1, " "},
    // eight dashes: one past the longest code
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_NONE,    DashChar, 1'b1, 8'h00},
    // foreign characters at both ends of the byte range
    '{ROW_PREDICT, 8'h00,    1'b0, 8'h00},
    '{ROW_NONE,    8'hff,    1'b1, 8'h00},
    // ampersand in its standard form
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_CHAR,    DotChar,  1'b1, "&"},
    // dash as separator: it ends the symbol instead of extending it
    '{ROW_SEP,     DashChar, 1'b0, 8'h00},
    '{ROW_PREDICT, DotChar,  1'b0, 8'h00},
    '{ROW_CHAR,    DashChar, 1'b0, "e"},
    '{ROW_NONE,    DashChar, 1'b0, 8'h00}
  };

  // dut ports
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          symbol_char_i;
  logic                is_last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          decoded_char_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // predictor state: separator and the symbol being gathered
  logic [7:0] sep_char;
  logic [6:0] acc_bits;
  int         acc_len;
  bit         acc_bad;

  // code table, keyed by {length, elements} with dash = 1
  logic [7:0] letter_of [bit [9:0]];
  string      code_pats [$];

  logic [7:0] letters_due [$];
  int         err_cnt;

  // idle shaping, shared with the stall process
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  bit hold_seen;
  int hold_left;

  morse_code_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_char_i  (symbol_char_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_char_o (decoded_char_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // hard stop in case the decoder hangs
  initial begin
    #(LIMIT_NS);
    $display("morse_code_decoder: mismatch");
    $finish;
  end

  // receiver stall: random per cycle, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // result checker: every accepted letter against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (letters_due.size() == 0) begin
        $display("%0t: unexpected letter, expected none, actual %h", $time, decoded_char_o);
        err_cnt++;
      end else begin
        if (decoded_char_o !== letters_due[0]) begin
          $display("%0t: decoded_char expected %h actual %h",
                   $time, letters_due[0], decoded_char_o);
          err_cnt++;
        end
        void'(letters_due.pop_front());
      end
    end
  end

  task automatic add_code(input string pat, input logic [7:0] letter);
    logic [6:0] bits;
    logic [2:0] len;
    bits = '0;
    len  = 3'(pat.len());
    for (int k = 0; k < pat.len(); k++) begin
      bits = {bits[5:0], pat[k] == DashChar};
    end
    letter_of[{len, bits}] = letter;
    code_pats.push_back(pat);
  endtask

  task automatic fill_code_table();
    add_code(".-", "a");     add_code("-...", "b");   add_code("-.-.", "c");
    add_code("-..", "d");    add_code(".", "e");      add_code("..-.", "f");
    add_code("--.", "g");    add_code("....", "h");   add_code("..", "i");
    add_code(".---", "j");   add_code("-.-", "k");    add_code(".-..", "l");
    add_code("--", "m");     add_code("-.", "n");     add_code("---", "o");
    add_code(".--.", "p");   add_code("--.-", "q");   add_code(".-.", "r");
    add_code("...", "s");    add_code("-", "t");      add_code("..-", "u");
    add_code("...-", "v");   add_code(".--", "w");    add_code("-..-", "x");
    add_code("-.--", "y");   add_code("--..", "z");
    add_code("-----", "0");  add_code(".----", "1");  add_code("..---", "2");
    add_code("...--", "3");  add_code("....-", "4");  add_code(".....", "5");
    add_code("-....", "6");  add_code("--...", "7");  add_code("---..", "8");
    add_code("----.", "9");
    add_code(".-.-.-", "."); add_code("---...", ":"); add_code("--..--", ",");
    add_code("-.-.-.", ";"); add_code("..--..", "?"); add_code("-...-", "=");
    add_code(".----.", "'"); add_code("-..-.", "/");  add_code("-.-.--", "!");
    add_code("-....-", " "); add_code("..--.-", "_"); add_code(".-..-.", 8'h22);
    add_code("-.--.", "(");  add_code("-.--.-", ")"); add_code("...-..-", "$");
    add_code(".-...", "&");  add_code(".--.-.", "@"); add_code(".-.-.", "+");
  endtask

  // one character through the predicted decoder
  task automatic decode_step(input logic [7:0] ch, input logic last,
                             output bit hit, output logic [7:0] letter);
    bit [9:0] key;
    hit    = 1'b0;
    letter = '0;
    if (ch != sep_char) begin
      if (ch == DotChar || ch == DashChar) begin
        // an element past the longest code spoils the symbol, not stored
        if (acc_len >= MAX_CODE_LEN) begin
          acc_bad = 1'b1;
        end else begin
          acc_bits = {acc_bits[5:0], ch == DashChar};
          acc_len++;
        end
      end else begin
        acc_bad = 1'b1;
      end
      if (!last) return;
    end
    key = {acc_len[2:0], acc_bits};
    if (!acc_bad && acc_len != 0 && letter_of.exists(key)) begin
      hit    = 1'b1;
      letter = letter_of[key];
    end
    acc_bits = '0;
    acc_len  = 0;
    acc_bad  = 1'b0;
  endtask

  // offer one request, wait for it to be taken, then record the expectation
  task automatic send_char(input logic [7:0] ch, input logic last,
                           input row_kind_e kind, input logic [7:0] typed);
    bit         hit;
    logic [7:0] letter;
    // sender gaps, valid stays high between back-to-back requests
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    symbol_char_i <= ch;
    is_last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_step(ch, last, hit, letter);
    case (kind)
      ROW_PREDICT: if (hit) letters_due.push_back(letter);
      ROW_CHAR:    letters_due.push_back(typed);
      default:     ;
    endcase
  endtask

  // drop valid, let every letter come out, then idle for SETTLE_CYCLES
  task automatic settle_decoder();
    in_valid_i <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SEP_ADDR) sep_char = data[7:0];
  endtask

  task automatic apb_read(input logic [CfgAddrW-1:0] addr, output logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // separator write with random upper bits, then readback
  task automatic set_separator(input logic [7:0] value);
    logic [CfgDataW-1:0] rd;
    apb_write(SEP_ADDR, {24'($urandom_range(32'hffffff)), value});
    apb_read(SEP_ADDR, rd);
    if (rd !== {{(CfgDataW-8){1'b0}}, sep_char}) begin
      $display("%0t: separator readback expected %h actual %h", $time, sep_char, rd);
      err_cnt++;
    end
  endtask

  // mostly table codes with random content, some raw runs and noise
  task automatic random_phase(input int n_items);
    int         sent;
    int         pick;
    int         len;
    bit         end_last;
    string      pat;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed code from the table
        pat      = code_pats[$urandom_range(code_pats.size() - 1)];
        end_last = ($urandom_range(9) == 0);
        for (int k = 0; k < pat.len(); k++) begin
          ch = (pat[k] == DashChar) ? DashChar : DotChar;
          send_char(ch, end_last && (k == pat.len() - 1), ROW_PREDICT, '0);
        end
        sent += pat.len();
        if (!end_last) begin
          send_char(sep_char, 1'($urandom_range(1)), ROW_PREDICT, '0);
          sent++;
        end
      end else if (pick < 88) begin
        // raw dot/dash run, sometimes too long or spoiled by a stray byte
        len = $urandom_range(1, 9);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(19) == 0) ch = 8'($urandom_range(255));
          else ch = $urandom_range(1) ? DashChar : DotChar;
          send_char(ch, ($urandom_range(15) == 0), ROW_PREDICT, '0);
        end
        send_char(sep_char, 1'b0, ROW_PREDICT, '0);
        sent += len + 1;
      end else begin
        // plain noise across the whole byte range
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)), ROW_PREDICT, '0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] phase_sep [NUM_PHASES];
    dir_row_t   row;

    // every input known from time zero, reset held low
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    symbol_char_i = '0;
    is_last_i     = 1'b0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    hold_seen     = 1'b0;
    hold_left     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    err_cnt       = 0;

    // predictor after reset
    sep_char = SepResetChar;
    acc_bits = '0;
    acc_len  = 0;
    acc_bad  = 1'b0;
    fill_code_table();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    tx_idle_pct = 35;
    rx_idle_pct = 51;
    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_SEP) begin
        settle_decoder();
        set_separator(row.ch);
      end else begin
        send_char(row.ch, row.last, row.kind, row.letter);
      end
    end

    // separator per phase: both byte extremes, dot, dash, space, random
    phase_sep[0] = 8'h00;
    phase_sep[1] = 8'hff;
    phase_sep[2] = DotChar;
    phase_sep[3] = DashChar;
    phase_sep[4] = SepResetChar;
    phase_sep[5] = 8'($urandom_range(255));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_decoder();
      // a write to an undecoded address must leave the separator alone
      apb_write(SPARE_ADDR, $urandom());
      set_separator(phase_sep[p]);
      if (p < 2) begin
        tx_idle_pct = 35;
        rx_idle_pct = 51;
      end else if (p < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_req <= ~hold_req;
      random_phase(PHASE_ITEMS);
    end

    settle_decoder();
    if (err_cnt == 0) begin
      $display("morse_code_decoder: match");
    end else begin
      $display("morse_code_decoder: mismatch");
    end
    $finish;
  end

endmodule
